// ===== design/bde_pkg.sv =====
// Shared types and constants for the bounded deque engine.
`default_nettype none
package bde_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // fixed beat field widths
  localparam int FUNC_W     = 3;
  localparam int VALUE_W    = 32;
  localparam int OUT_DATA_W = 32;
  localparam int POS_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int ENTRIES_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_LIST       = 3'd4,
    FUNC_CLEAR      = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } ctrl_state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHR,   // take left neighbour (towards back)
    CELL_SHL,   // take right neighbour (towards front)
    CELL_LOAD   // write push word into the cell at the back
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [CNT_W-1:0] count;
  } chain_ctl_t;

endpackage
`default_nettype wire

// ===== design/bde_in_if.sv =====
// Request channel: operation and push word.
`default_nettype none
interface bde_in_if;
  import bde_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface
`default_nettype wire

// ===== design/bde_out_if.sv =====
// Response channel: result beats.
`default_nettype none
interface bde_out_if;
  import bde_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [OUT_DATA_W-1:0] data;
  logic [POS_W-1:0]             position;
  logic [STATUS_W-1:0]          status;
  logic [ENTRIES_W-1:0]         entries;
  logic                         last;

  modport source (output valid, data, position, status, entries, last, input ready);
  modport sink   (input valid, data, position, status, entries, last, output ready);
endinterface
`default_nettype wire

// ===== design/bde_cell.sv =====
// One storage cell of the deque chain.
`default_nettype none
module bde_cell (
  input  wire logic                           clk_i,
  input  wire bde_pkg::cell_op_e              op_i,
  input  wire logic [bde_pkg::DATA_WIDTH-1:0] left_i,
  input  wire logic [bde_pkg::DATA_WIDTH-1:0] right_i,
  input  wire logic [bde_pkg::DATA_WIDTH-1:0] load_i,
  output logic      [bde_pkg::DATA_WIDTH-1:0] data_o
);
  import bde_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    case (op_i)
      CELL_SHR:  data_d = left_i;
      CELL_SHL:  data_d = right_i;
      CELL_LOAD: data_d = load_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== design/bde_ctrl.sv =====
// Sequencer: decodes operations, tracks fill level and drives the result register.
`default_nettype none
module bde_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  bde_in_if.sink                              in_i,
  bde_out_if.source                           out_o,
  input  wire logic [bde_pkg::DATA_WIDTH-1:0] front_data_i,
  input  wire logic [bde_pkg::DATA_WIDTH-1:0] back_data_i,
  output bde_pkg::chain_ctl_t                 chain_ctl_o,
  output logic      [bde_pkg::DATA_WIDTH-1:0] push_word_o
);
  import bde_pkg::*;

  ctrl_state_e           state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] data_q, data_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  status_e               status_q, status_d;
  logic [ENTRIES_W-1:0]  entries_q, entries_d;
  logic                  last_q, last_d;
  logic                  can_load;
  logic                  in_acc;
  cell_op_e              op;

  assign can_load    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && can_load;
  assign in_acc      = in_i.valid && in_i.ready;
  assign push_word_o = DATA_WIDTH'($unsigned(in_i.value));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    data_d      = data_q;
    pos_d       = pos_q;
    status_d    = status_q;
    entries_d   = entries_q;
    last_d      = last_q;
    op          = CELL_HOLD;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_d = 1'b1;
          data_d      = '0;
          pos_d       = '0;
          status_d    = STATUS_OK;
          last_d      = 1'b1;
          case (in_i.func) inside
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                status_d = STATUS_FULL;
              end else begin
                op      = (in_i.func == FUNC_PUSH_FRONT) ? CELL_SHR : CELL_LOAD;
                count_d = count_q + 1'b1;
              end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                if (in_i.func == FUNC_POP_FRONT) begin
                  data_d = OUT_DATA_W'(front_data_i);
                  op     = CELL_SHL;
                end else begin
                  data_d = OUT_DATA_W'(back_data_i);
                end
                count_d = count_q - 1'b1;
              end
            end
            FUNC_LIST: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                // entries stream from the list state instead
                out_valid_d = out_valid_q && !out_o.ready;
                state_d     = ST_LIST;
                idx_d       = '0;
              end
            end
            FUNC_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
          entries_d = ENTRIES_W'(count_d);
        end
      end
      ST_LIST: begin
        // full rotation of the chain: front beats out first, then spin back in place
        if (idx_q < count_q) begin
          if (can_load) begin
            out_valid_d = 1'b1;
            data_d      = OUT_DATA_W'(front_data_i);
            pos_d       = POS_W'(idx_q);
            status_d    = STATUS_OK;
            entries_d   = ENTRIES_W'(count_q);
            last_d      = (idx_q == count_q - 1'b1);
            op          = CELL_SHL;
            idx_d       = idx_q + 1'b1;
          end
        end else begin
          op    = CELL_SHL;
          idx_d = idx_q + 1'b1;
        end
        if (op == CELL_SHL && idx_q == CNT_W'(CAPACITY - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign chain_ctl_o.op    = op;
  assign chain_ctl_o.count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q    <= data_d;
    pos_q     <= pos_d;
    status_q  <= status_d;
    entries_q <= entries_d;
    last_q    <= last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data     = data_q;
  assign out_o.position = pos_q;
  assign out_o.status   = status_q;
  assign out_o.entries  = entries_q;
  assign out_o.last     = last_q;

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.func == FUNC_PUSH_FRONT || in_i.func == FUNC_PUSH_BACK)
      && count_q != CNT_W'(CAPACITY)
    |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the fill level");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.func == FUNC_POP_FRONT || in_i.func == FUNC_POP_BACK)
      && count_q != '0
    |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not shrink the fill level");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.func == FUNC_CLEAR |=> count_q == '0)
    else $error("clear left entries behind");

  a_list_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST |-> !in_i.ready && $stable(count_q))
    else $error("input taken or fill level moved during a listing");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> count_q <= CNT_W'(CAPACITY))
    else $error("fill level beyond capacity");

endmodule
`default_nettype wire

// ===== design/bounded_deque_engine.sv =====
// Push/pop/clear result: one beat, registered, in the cycle after the request beat.
// Push, pop and clear sustain one request per cycle while results are taken.
// A listing streams one beat per cycle while beats are taken, front first, as the cell chain rotates;
// the chain makes a full turn, and a listing holds off requests until that turn is complete,
// which takes longer while result beats are stalled.
// Reset empties the deque and drops any pending result; cell contents are not cleared.
`default_nettype none
module bounded_deque_engine (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bde_in_if.sink    in_i,
  bde_out_if.source out_o
);
  import bde_pkg::*;

  chain_ctl_t            chain_ctl;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] back_data;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  cell_op_e              cell_op   [CAPACITY];

  bde_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .front_data_i (cell_data[0]),
    .back_data_i  (back_data),
    .chain_ctl_o  (chain_ctl),
    .push_word_o  (push_word)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // a load only lands in the first free cell
    always_comb begin
      if (chain_ctl.op == CELL_LOAD) begin
        cell_op[i] = (chain_ctl.count == CNT_W'(i)) ? CELL_LOAD : CELL_HOLD;
      end else begin
        cell_op[i] = chain_ctl.op;
      end
    end

    bde_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .left_i  ((i == 0) ? push_word : cell_data[(i + CAPACITY - 1) % CAPACITY]),
      .right_i (cell_data[(i + 1) % CAPACITY]),
      .load_i  (push_word),
      .data_o  (cell_data[i])
    );
  end

  // back entry: one-hot pick of the cell just below the fill level
  always_comb begin
    back_data = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (chain_ctl.count == CNT_W'(j + 1)) begin
        back_data = back_data | cell_data[j];
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/bounded_deque_engine_tb.sv =====
// Self-checking testbench for the bounded deque engine: directed table, then random traffic.
`timescale 1ns / 100ps
`default_nettype none
module bounded_deque_engine_tb;
  import bde_pkg::*;

  localparam int          RANDOM_ITEMS = 450;
  localparam int          SEGMENT_LEN  = 30;
  localparam int unsigned CYCLE_LIMIT  = 500_000;

  // selector codes the block treats as no-ops
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  // traffic mixes for the random part
  localparam int MIX_FILL    = 0;
  localparam int MIX_DRAIN   = 1;
  localparam int MIX_BALANCE = 2;

  typedef struct {
    logic signed [OUT_DATA_W-1:0] data;
    logic [POS_W-1:0]             position;
    logic [STATUS_W-1:0]          status;
    logic [ENTRIES_W-1:0]         entries;
    logic                         last;
  } beat_t;

  // a request whose single response beat is written down in the table
  typedef struct {
    bit    typed;
    beat_t beat;
  } pinned_t;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    int                 reps;
    bit                 typed;
    beat_t              beat;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  bde_in_if  req_if ();
  bde_out_if rsp_if ();

  bounded_deque_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // shadow deque
  logic [DATA_WIDTH-1:0] ring_words [CAPACITY];
  int                    front_idx;
  int                    held;

  beat_t       beat_q [$];
  pinned_t     pinned_q [$];
  stim_row_t   dir_rows [$];
  int          errors;
  int unsigned cycle_count;
  bit          quiet_phase;
  pinned_t     cur_pin;
  beat_t       want;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic beat_t make_beat(logic [OUT_DATA_W-1:0] d, int pos,
                                      logic [STATUS_W-1:0] st, bit lst);
    beat_t b;
    b.data     = d;
    b.position = pos[POS_W-1:0];
    b.status   = st;
    b.entries  = held[ENTRIES_W-1:0];
    b.last     = lst;
    return b;
  endfunction

  // Apply one accepted request to the shadow deque and queue the beats it yields.
  task automatic deque_apply(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                             input pinned_t pin);
    beat_t made [$];
    int    k;
    case (f)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (held >= CAPACITY) begin
          made.push_back(make_beat('0, 0, STATUS_FULL, 1'b1));
        end else begin
          if (f == FUNC_PUSH_FRONT) begin
            front_idx = (front_idx + CAPACITY - 1) % CAPACITY;
            ring_words[front_idx] = v[DATA_WIDTH-1:0];
          end else begin
            ring_words[(front_idx + held) % CAPACITY] = v[DATA_WIDTH-1:0];
          end
          held++;
          made.push_back(make_beat('0, 0, STATUS_OK, 1'b1));
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (held == 0) begin
          made.push_back(make_beat('0, 0, STATUS_EMPTY, 1'b1));
        end else begin
          if (f == FUNC_POP_FRONT) begin
            k = front_idx;
            front_idx = (front_idx + 1) % CAPACITY;
          end else begin
            k = (front_idx + held - 1) % CAPACITY;
          end
          held--;
          made.push_back(make_beat(ring_words[k][OUT_DATA_W-1:0], 0, STATUS_OK, 1'b1));
        end
      end
      FUNC_LIST: begin
        if (held == 0) begin
          made.push_back(make_beat('0, 0, STATUS_EMPTY, 1'b1));
        end else begin
          for (k = 0; k < held; k++)
            made.push_back(make_beat(ring_words[(front_idx + k) % CAPACITY][OUT_DATA_W-1:0],
                                     k, STATUS_OK, k == held - 1));
        end
      end
      FUNC_CLEAR: begin
        front_idx = 0;
        held      = 0;
        made.push_back(make_beat('0, 0, STATUS_OK, 1'b1));
      end
      default: begin
        made.push_back(make_beat('0, 0, STATUS_OK, 1'b1));
      end
    endcase
    if (pin.typed) beat_q.push_back(pin.beat);
    else foreach (made[i]) beat_q.push_back(made[i]);
  endtask

  // Requests are predicted in the same process that checks beats, so ordering is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        cur_pin = pinned_q.pop_front();
        deque_apply(req_if.func, req_if.value, cur_pin);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (beat_q.size() == 0) begin
          $error("result beat with nothing expected: data %0d status %0d",
                 rsp_if.data, rsp_if.status);
          errors++;
        end else begin
          want = beat_q.pop_front();
          if (rsp_if.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, rsp_if.data);
            errors++;
          end
          if (rsp_if.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp_if.position);
            errors++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            errors++;
          end
          if (rsp_if.entries !== want.entries) begin
            $error("entries: expected %0d, got %0d", want.entries, rsp_if.entries);
            errors++;
          end
          if (rsp_if.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_if.last);
            errors++;
          end
        end
      end
    end
  end

  // result side: random stall before each beat, none in a quiet phase
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 8);
      @(negedge clk_i);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                           input bit typed, input beat_t b);
    int      gap;
    pinned_t pin;
    gap = quiet_phase ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pin.typed = typed;
    pin.beat  = b;
    pinned_q.push_back(pin);
    req_if.valid <= 1'b1;
    req_if.func  <= f;
    req_if.value <= v;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // drop valid so the last request is not taken again, then wait for every beat
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (beat_q.size() != 0);
  endtask

  function automatic stim_row_t stim_row(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                                         int reps, bit typed = 1'b0,
                                         logic [STATUS_W-1:0] st = STATUS_OK,
                                         int ent = 0, logic [OUT_DATA_W-1:0] d = '0);
    stim_row_t r;
    r.func          = f;
    r.value         = v;
    r.reps          = reps;
    r.typed         = typed;
    r.beat.data     = d;
    r.beat.position = '0;
    r.beat.status   = st;
    r.beat.entries  = ent[ENTRIES_W-1:0];
    r.beat.last     = 1'b1;
    return r;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(int mix);
    int r;
    int push_pct;
    int pop_pct;
    r        = $urandom_range(0, 99);
    push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 25 : 45;
    pop_pct  = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 60 : 35;
    if (r < push_pct)
      return ($urandom_range(0, 1) != 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
    if (r < push_pct + pop_pct)
      return ($urandom_range(0, 1) != 0) ? FUNC_POP_FRONT : FUNC_POP_BACK;
    if (r < 96) return FUNC_LIST;
    if (r < 98) return FUNC_CLEAR;
    return ($urandom_range(0, 1) != 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int    n;
    int    mix;
    bit    paused;
    beat_t no_beat;
    errors       = 0;
    paused       = 1'b0;
    quiet_phase  = 1'b0;
    front_idx    = 0;
    held         = 0;
    no_beat      = '{default: '0};
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.func  = '0;
    req_if.value = '0;

    // empty-queue errors, extremes, no-op selectors, fill to full with a wrapped head
    dir_rows.push_back(stim_row(FUNC_POP_FRONT,  '0, 1, 1, STATUS_EMPTY, 0));
    dir_rows.push_back(stim_row(FUNC_LIST,       '0, 1, 1, STATUS_EMPTY, 0));
    dir_rows.push_back(stim_row(FUNC_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1, STATUS_OK, 1));
    dir_rows.push_back(stim_row(FUNC_PUSH_BACK,  32'h8000_0000, 1, 1, STATUS_OK, 2));
    dir_rows.push_back(stim_row(FUNC_PUSH_FRONT, 32'h0000_0000, 1, 1, STATUS_OK, 3));
    dir_rows.push_back(stim_row(FUNC_LIST,       '0, 1));
    dir_rows.push_back(stim_row(FUNC_POP_BACK,   '0, 1, 1, STATUS_OK, 2, 32'h8000_0000));
    dir_rows.push_back(stim_row(FUNC_SPARE_6,    32'hFFFF_FFFF, 1, 1, STATUS_OK, 2));
    dir_rows.push_back(stim_row(FUNC_SPARE_7,    32'hFFFF_FFFF, 1, 1, STATUS_OK, 2));
    dir_rows.push_back(stim_row(FUNC_PUSH_FRONT, '0, CAPACITY - 2));
    dir_rows.push_back(stim_row(FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1, STATUS_FULL, CAPACITY));
    dir_rows.push_back(stim_row(FUNC_PUSH_BACK,  32'hFFFF_FFFF, 1, 1, STATUS_FULL, CAPACITY));
    dir_rows.push_back(stim_row(FUNC_LIST,       '0, 1));
    dir_rows.push_back(stim_row(FUNC_POP_BACK,   '0, 1, 1, STATUS_OK, CAPACITY - 1,
                                32'h7FFF_FFFF));
    dir_rows.push_back(stim_row(FUNC_CLEAR,      '0, 1, 1, STATUS_OK, 0));
    dir_rows.push_back(stim_row(FUNC_LIST,       '0, 1, 1, STATUS_EMPTY, 0));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].reps > 1)
        repeat (dir_rows[i].reps) send_item(dir_rows[i].func, $urandom, 1'b0, no_beat);
      else
        send_item(dir_rows[i].func, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].beat);
    end
    wait_drained();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      mix         = $urandom_range(MIX_FILL, MIX_BALANCE);
      quiet_phase = ($urandom_range(0, 3) == 0);
      repeat (SEGMENT_LEN) begin
        send_item(pick_func(mix), pick_value(), 1'b0, no_beat);
        n++;
      end
      // once past the halfway mark, hold the request side until every beat so far has come back
      if (!paused && n >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    quiet_phase  = 1'b0;
    wait_drained();
    repeat (CAPACITY + 4) @(posedge clk_i);

    if (errors == 0 && beat_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
